/* src/fcc_pkg.sv */
// Shared types, constants and the byte-wide CRC-32 update for the frame checker.
// No dependencies; the modules that use it refer to it by scoped names.
`default_nettype none

package fcc_pkg;

  // Frame layout
  localparam int unsigned HDR_BYTES = 10;
  localparam int unsigned CRC_BYTES = 4;
  localparam int unsigned POS_W     = 17;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Reflected IEEE CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

  // Configuration reset values
  localparam logic [15:0] MAGIC_RESET       = 16'd0;
  localparam logic [7:0]  VERSION_RESET     = 8'd1;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_LENGTH  = 3'd4,
    ST_CRC     = 3'd5
  } fcc_status_t;

  typedef struct packed {
    logic [15:0] magic_word;
    logic [7:0]  version_byte;
    logic [15:0] max_payload;
  } fcc_cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    fcc_status_t status;
    logic [7:0]  msg_type;
    logic [7:0]  sequence_number;
    logic [15:0] command_code;
    logic [15:0] payload_count;
  } fcc_result_t;

  // Fold one byte into the CRC register, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/fcc_in_stage.sv */
// Input register of the frame checker: holds one received byte and its last flag.
// Depends on nothing beyond the handshake from the top level.
`default_nettype none

module fcc_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire logic       advance,
  output logic            s_valid,
  output logic [7:0]      s_byte,
  output logic            s_last
);

  // Take a new byte when empty or when the held one moves on
  assign in_ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_byte <= data_byte;
      s_last <= last_byte;
    end
  end

endmodule

`default_nettype wire

/* src/fcc_parse.sv */
// Frame parser: byte position, header store, running CRC, trailer and verdict logic.
// Uses fcc_pkg for layout constants, status codes, result struct and the CRC update.
`default_nettype none

module fcc_parse (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic            in_valid,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  input  wire fcc_pkg::fcc_cfg_t cfg,
  output logic                 has_result,
  output fcc_pkg::fcc_result_t result
);

  localparam int unsigned PW = fcc_pkg::POS_W;

  logic [PW-1:0]   byte_position, pos_next;
  logic [31:0]     running_crc, crc_next, crc_upd;
  logic [9:0][7:0] header_store, hdr_next;
  logic [31:0]     trailer_crc, trailer_next;
  logic [15:0]     len, len_v;
  logic [PW:0]     hdr_end, trl_end;
  logic [PW-1:0]   frame_len;
  logic            in_hdr, in_pay, in_trl;
  fcc_pkg::fcc_status_t verdict;

  // Region of the current byte, judged with the header as it stood before it
  assign len     = {header_store[9], header_store[8]};
  assign hdr_end = (PW+1)'(fcc_pkg::HDR_BYTES) + (PW+1)'(len);
  assign trl_end = hdr_end + (PW+1)'(fcc_pkg::CRC_BYTES);
  assign in_hdr  = byte_position < PW'(fcc_pkg::HDR_BYTES);
  assign in_pay  = !in_hdr && ({1'b0, byte_position} < hdr_end);
  assign in_trl  = !in_hdr && !in_pay && ({1'b0, byte_position} < trl_end);
  assign crc_upd = fcc_pkg::crc_byte(running_crc, data_byte);

  // Update the frame state for this byte
  always_comb begin
    hdr_next     = header_store;
    crc_next     = running_crc;
    trailer_next = trailer_crc;
    if (in_hdr) begin
      hdr_next[byte_position[3:0]] = data_byte;
      crc_next = crc_upd;
    end else if (in_pay) begin
      crc_next = crc_upd;
    end else if (in_trl) begin
      trailer_next = {data_byte, trailer_crc[31:8]};
    end
    pos_next = (byte_position < fcc_pkg::POS_MAX) ? byte_position + PW'(1)
                                                  : fcc_pkg::POS_MAX;
  end

  // Verdict over the updated state, first failing check wins
  assign len_v     = {hdr_next[9], hdr_next[8]};
  assign frame_len = PW'(fcc_pkg::HDR_BYTES) + PW'(len_v) + PW'(fcc_pkg::CRC_BYTES);

  always_comb begin
    if (pos_next < PW'(fcc_pkg::HDR_BYTES + fcc_pkg::CRC_BYTES)) begin
      verdict = fcc_pkg::ST_SHORT;
    end else if ({hdr_next[1], hdr_next[0]} != cfg.magic_word) begin
      verdict = fcc_pkg::ST_MAGIC;
    end else if (hdr_next[2] != cfg.version_byte) begin
      verdict = fcc_pkg::ST_VERSION;
    end else if (len_v > cfg.max_payload) begin
      verdict = fcc_pkg::ST_LENGTH;
    end else if (pos_next != frame_len) begin
      verdict = fcc_pkg::ST_LENGTH;
    end else if (trailer_next != ~crc_next) begin
      verdict = fcc_pkg::ST_CRC;
    end else begin
      verdict = fcc_pkg::ST_OK;
    end
  end

  // Build the outgoing item: pass payload on, or give the verdict on the last byte
  assign has_result = in_valid && (last_byte || in_pay);

  always_comb begin
    result = '0;
    if (last_byte) begin
      result.kind            = 1'b1;
      result.status          = verdict;
      result.msg_type        = hdr_next[3];
      result.sequence_number = hdr_next[4];
      result.command_code    = {hdr_next[7], hdr_next[6]};
      result.payload_count   = len_v;
    end else begin
      result.kind         = 1'b0;
      result.payload_byte = data_byte;
      result.status       = fcc_pkg::ST_OK;
    end
  end

  // Advance state; the last byte returns it to the start of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_crc   <= fcc_pkg::CRC_INIT;
      header_store  <= '0;
      trailer_crc   <= '0;
    end else if (step) begin
      if (last_byte) begin
        byte_position <= '0;
        running_crc   <= fcc_pkg::CRC_INIT;
        header_store  <= '0;
        trailer_crc   <= '0;
      end else begin
        byte_position <= pos_next;
        running_crc   <= crc_next;
        header_store  <= hdr_next;
        trailer_crc   <= trailer_next;
      end
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    step && last_byte |=> byte_position == '0 && running_crc == fcc_pkg::CRC_INIT)
    else $error("frame state not cleared after verdict");

  a_hdr_frozen: assert property (@(posedge clk) disable iff (rst)
    step && !last_byte && !in_hdr |=> $stable(header_store))
    else $error("header store changed past the header");

  a_pos_count: assert property (@(posedge clk) disable iff (rst)
    step && !last_byte && byte_position != fcc_pkg::POS_MAX
    |=> byte_position == $past(byte_position) + PW'(1))
    else $error("byte position did not advance");

endmodule

`default_nettype wire

/* src/fcc_out_stage.sv */
// Output register of the frame checker: holds one result until the receiver takes it.
// Uses fcc_pkg for the result struct.
`default_nettype none

module fcc_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire fcc_pkg::fcc_result_t d,
  output logic                      free,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output fcc_pkg::fcc_result_t      q
);

  // Slot opens when empty or when its item transfers this cycle
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result loaded over a held result");

endmodule

`default_nettype wire

/* src/frame_checker_crc32.sv */
// Frame checker for length-prefixed frames with CRC-32: top level.
// Depends on fcc_pkg, fcc_in_stage, fcc_parse and fcc_out_stage.
//
// Usage:
//   Bytes enter on in_valid/in_ready with data_byte and last_byte. Each payload
//   byte (indices 10 on, up to the header length) leaves on out_valid/out_ready
//   with kind 0, except on the last byte, which gives a single verdict item with
//   kind 1, the status and the header fields. Header and trailer bytes give no
//   output. The configuration port (cfg_we, cfg_index, cfg_data) sets the
//   expected magic, version and largest payload; write it between frames.
//   An accepted byte waits in the input register; its result, if any, then
//   goes to the output register and out_valid. Throughput: one byte per cycle
//   while the receiver keeps up, set by the byte-wide CRC update in between.
//   Reset clears the frame state and the configuration to defaults (magic 0,
//   version 1, max payload 1024). When the receiver stalls the output register
//   holds its item, one more byte waits in the input register, and then
//   in_ready drops until the output transfers.
`default_nettype none

module frame_checker_crc32 (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      data_byte,
  input  wire logic                            last_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 kind,
  output logic [7:0]                           payload_byte,
  output logic [2:0]                           status,
  output logic [7:0]                           msg_type,
  output logic [7:0]                           sequence_number,
  output logic [15:0]                          command_code,
  output logic [15:0]                          payload_count,
  input  wire logic                            cfg_we,
  input  wire logic [fcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [15:0]                     cfg_data
);

  fcc_pkg::fcc_cfg_t    cfg;
  fcc_pkg::fcc_result_t res_d, res_q;
  logic                 s_valid, s_last, advance, free, has_result;
  logic [7:0]           s_byte;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word   <= fcc_pkg::MAGIC_RESET;
      cfg.version_byte <= fcc_pkg::VERSION_RESET;
      cfg.max_payload  <= fcc_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fcc_pkg::CFG_MAGIC:       cfg.magic_word   <= cfg_data;
        fcc_pkg::CFG_VERSION:     cfg.version_byte <= cfg_data[7:0];
        fcc_pkg::CFG_MAX_PAYLOAD: cfg.max_payload  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Move the held byte on whenever the output slot can take its result
  assign advance = s_valid && free;

  fcc_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .advance   (advance),
    .s_valid   (s_valid),
    .s_byte    (s_byte),
    .s_last    (s_last)
  );

  fcc_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .in_valid   (s_valid),
    .data_byte  (s_byte),
    .last_byte  (s_last),
    .cfg        (cfg),
    .has_result (has_result),
    .result     (res_d)
  );

  fcc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && has_result),
    .d         (res_d),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .q         (res_q)
  );

  // Spread the result onto its ports
  assign kind            = res_q.kind;
  assign payload_byte    = res_q.payload_byte;
  assign status          = res_q.status;
  assign msg_type        = res_q.msg_type;
  assign sequence_number = res_q.sequence_number;
  assign command_code    = res_q.command_code;
  assign payload_count   = res_q.payload_count;

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for frame_checker_crc32: random frames, good and broken,
// checked against a predictor of the byte stream and the frame verdicts.
// Depends on fcc_pkg and frame_checker_crc32.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Predict passed-on payload bytes and verdicts; match them against the block
  class frame_predictor;
    logic [15:0] cfg_magic;
    logic [7:0]  cfg_version;
    logic [15:0] cfg_max_payload;
    logic [16:0] byte_pos;
    logic [31:0] crc_acc;
    logic [7:0]  hdr [10];
    logic [31:0] rx_crc;
    fcc_pkg::fcc_result_t pending_results[$];
    int unsigned failures;

    function new();
      cfg_magic       = fcc_pkg::MAGIC_RESET;
      cfg_version     = fcc_pkg::VERSION_RESET;
      cfg_max_payload = fcc_pkg::MAX_PAYLOAD_RESET;
      failures        = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      byte_pos = '0;
      crc_acc  = fcc_pkg::CRC_INIT;
      rx_crc   = '0;
      foreach (hdr[i]) hdr[i] = 8'd0;
    endfunction

    // Reflected CRC-32, one data bit at a time
    function logic [31:0] crc_step(logic [31:0] acc, logic [7:0] d);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb  = acc[0] ^ d[i];
        acc = acc >> 1;
        if (fb) acc ^= fcc_pkg::CRC_POLY;
      end
      return acc;
    endfunction

    function void write_reg(logic [fcc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
      case (idx)
        fcc_pkg::CFG_MAGIC:       cfg_magic = value;
        fcc_pkg::CFG_VERSION:     cfg_version = value[7:0];
        fcc_pkg::CFG_MAX_PAYLOAD: cfg_max_payload = value;
        default: ;
      endcase
    endfunction

    // Note one accepted input byte and queue what it must produce
    function void take_byte(logic [7:0] d, logic is_last);
      int unsigned p, plen, total;
      fcc_pkg::fcc_result_t r;
      p    = int'(byte_pos);
      plen = int'({hdr[9], hdr[8]});
      if (p < fcc_pkg::HDR_BYTES) begin
        hdr[p]  = d;
        crc_acc = crc_step(crc_acc, d);
      end else if (p < fcc_pkg::HDR_BYTES + plen) begin
        crc_acc = crc_step(crc_acc, d);
      end else if (p < fcc_pkg::HDR_BYTES + plen + fcc_pkg::CRC_BYTES) begin
        rx_crc = {d, rx_crc[31:8]};
      end
      // Saturate the position counter
      if (byte_pos != fcc_pkg::POS_MAX) byte_pos = byte_pos + 1'b1;
      total = int'(byte_pos);
      r = '0;
      if (!is_last) begin
        if (p >= fcc_pkg::HDR_BYTES && p < fcc_pkg::HDR_BYTES + plen) begin
          r.kind         = 1'b0;
          r.payload_byte = d;
          pending_results.push_back(r);
        end
        return;
      end
      plen   = int'({hdr[9], hdr[8]});
      r.kind = 1'b1;
      if (total < fcc_pkg::HDR_BYTES + fcc_pkg::CRC_BYTES)
        r.status = fcc_pkg::ST_SHORT;
      else if ({hdr[1], hdr[0]} != cfg_magic)
        r.status = fcc_pkg::ST_MAGIC;
      else if (hdr[2] != cfg_version)
        r.status = fcc_pkg::ST_VERSION;
      else if (plen > cfg_max_payload ||
               total != fcc_pkg::HDR_BYTES + plen + fcc_pkg::CRC_BYTES)
        r.status = fcc_pkg::ST_LENGTH;
      else if (rx_crc != ~crc_acc)
        r.status = fcc_pkg::ST_CRC;
      else
        r.status = fcc_pkg::ST_OK;
      r.msg_type        = hdr[3];
      r.sequence_number = hdr[4];
      r.command_code    = {hdr[7], hdr[6]};
      r.payload_count   = plen[15:0];
      pending_results.push_back(r);
      restart_frame();
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        failures++;
      end
    endfunction

    // Match one output transfer against the oldest prediction
    function void check_result(fcc_pkg::fcc_result_t got);
      fcc_pkg::fcc_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected output transfer: kind %0d status %0d", got.kind, got.status);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare("kind", want.kind, got.kind);
      compare("payload_byte", want.payload_byte, got.payload_byte);
      compare("status", want.status, got.status);
      compare("msg_type", want.msg_type, got.msg_type);
      compare("sequence_number", want.sequence_number, got.sequence_number);
      compare("command_code", want.command_code, got.command_code);
      compare("payload_count", want.payload_count, got.payload_count);
    endfunction
  endclass

  typedef enum {
    FR_GOOD, FR_MAGIC, FR_VERSION, FR_OVERSIZE, FR_BOGUS_LEN,
    FR_LONGER, FR_SHORTER, FR_BAD_CRC, FR_SHORT, FR_NOISE
  } frame_shape_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    data_byte = 8'd0;
  logic                          last_byte = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          kind;
  logic [7:0]                    payload_byte;
  logic [2:0]                    status;
  logic [7:0]                    msg_type;
  logic [7:0]                    sequence_number;
  logic [15:0]                   command_code;
  logic [15:0]                   payload_count;
  logic                          cfg_we = 1'b0;
  logic [fcc_pkg::CFG_IDX_W-1:0] cfg_index = fcc_pkg::CFG_MAGIC;
  logic [15:0]                   cfg_data = 16'd0;

  frame_predictor sb;
  logic [7:0]     frame_bytes[$];
  int             bytes_sent = 0;
  bit             idle_allowed = 1'b1;
  bit             in_idle_on = 1'b0;
  bit             hold_req = 1'b0;

  frame_checker_crc32 dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .payload_byte(payload_byte), .status(status),
    .msg_type(msg_type), .sequence_number(sequence_number),
    .command_code(command_code), .payload_count(payload_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Offer one byte, with an occasional idle burst first, and wait for its transfer
  task automatic send_byte(input logic [7:0] d, input logic is_last);
    if (in_idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= is_last;
    do @(posedge clk); while (!in_ready);
    sb.take_byte(d, is_last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    in_idle_on = idle_allowed && ($urandom_range(0, 9) < 7);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Drop valid and wait until every predicted result has left the block
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input logic [15:0] magic, input logic [7:0] ver,
                             input logic [15:0] max_len);
    cfg_we    <= 1'b1;
    cfg_index <= fcc_pkg::CFG_MAGIC;
    cfg_data  <= magic;
    @(posedge clk);
    cfg_index <= fcc_pkg::CFG_VERSION;
    cfg_data  <= {8'd0, ver};
    @(posedge clk);
    cfg_index <= fcc_pkg::CFG_MAX_PAYLOAD;
    cfg_data  <= max_len;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(fcc_pkg::CFG_MAGIC, magic);
    sb.write_reg(fcc_pkg::CFG_VERSION, {8'd0, ver});
    sb.write_reg(fcc_pkg::CFG_MAX_PAYLOAD, max_len);
  endtask

  // Build a frame of the given shape; plen_req below zero picks a random length
  task automatic build_frame(input frame_shape_t shape, input int plen_req);
    logic [15:0] magic, plen;
    logic [7:0]  ver;
    logic [79:0] head;
    logic [31:0] crc;
    int          n, lim, cut;
    frame_bytes.delete();
    if (shape == FR_SHORT || shape == FR_NOISE) begin
      n = (shape == FR_SHORT) ? $urandom_range(1, 13) : $urandom_range(14, 40);
      repeat (n) frame_bytes.push_back(8'($urandom));
      return;
    end
    magic = sb.cfg_magic;
    ver   = sb.cfg_version;
    lim   = sb.cfg_max_payload;
    plen  = (plen_req >= 0) ? 16'(plen_req) : 16'($urandom_range(0, (lim < 40) ? lim : 40));
    n     = plen;
    case (shape)
      FR_MAGIC:   magic ^= 16'($urandom_range(1, 16'hFFFF));
      FR_VERSION: ver ^= 8'($urandom_range(1, 8'hFF));
      FR_OVERSIZE: begin
        plen = (lim == 16'hFFFF) ? 16'hFFFF :
               16'(lim + 1 + $urandom_range(0, (65534 - lim < 15) ? 65534 - lim : 15));
        n = $urandom_range(0, 30);
      end
      FR_BOGUS_LEN: begin
        plen = 16'($urandom);
        n    = $urandom_range(0, 30);
      end
      FR_LONGER: n = plen + $urandom_range(1, 6);
      default: ;
    endcase
    // Header: magic, version, type, sequence, reserved, command, length
    head = {plen, 16'($urandom), 24'($urandom), ver, magic};
    for (int i = 0; i < 10; i++) frame_bytes.push_back(head[8*i +: 8]);
    repeat (n) frame_bytes.push_back(8'($urandom));
    crc = fcc_pkg::CRC_INIT;
    foreach (frame_bytes[i]) crc = sb.crc_step(crc, frame_bytes[i]);
    crc = ~crc;
    if (shape == FR_BAD_CRC) crc ^= 32'd1 << $urandom_range(0, 31);
    for (int i = 0; i < 4; i++) frame_bytes.push_back(crc[8*i +: 8]);
    if (shape == FR_SHORTER) begin
      cut = $urandom_range(1, 8);
      repeat (cut) void'(frame_bytes.pop_back());
    end
  endtask

  // Receiver: check transfers, stall in bursts, honor a long hold-off on request
  initial begin
    fcc_pkg::fcc_result_t seen;
    int                   stall_left, hold_left, mode_left;
    bit                   calm;
    stall_left = 0;
    hold_left  = 0;
    mode_left  = 0;
    calm       = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        seen.kind            = kind;
        seen.payload_byte    = payload_byte;
        seen.status          = fcc_pkg::fcc_status_t'(status);
        seen.msg_type        = msg_type;
        seen.sequence_number = sequence_number;
        seen.command_code    = command_code;
        seen.payload_count   = payload_count;
        sb.check_result(seen);
      end
      if (mode_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_allowed && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    int           r, base;
    frame_shape_t shape;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: minimal good frame under reset settings, then a one-byte frame
    build_frame(FR_GOOD, 0);
    send_frame();
    frame_bytes.delete();
    frame_bytes.push_back(8'hFF);
    send_frame();

    base = bytes_sent;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: load_config(16'hFFFF, 8'h00, 16'd0);
          2: load_config(16'($urandom), 8'hFF, 16'hFFFF);
          3: load_config(16'($urandom), 8'($urandom), 16'd16);
          4: load_config(16'($urandom), 8'($urandom), 16'($urandom_range(0, 60)));
          default: load_config(16'($urandom), 8'($urandom), 16'd40);
        endcase
      end
      // Quiet tail with no idling on either side
      idle_allowed = (ph != 5);
      if (ph == 2) begin
        // Hold the receiver off while payload keeps coming
        build_frame(FR_GOOD, 30);
        hold_req = 1'b1;
        send_frame();
      end
      while (bytes_sent < base + (ph + 1) * 1750 / 6) begin
        r     = $urandom_range(0, 19);
        shape = (r >= 10 && r <= 18) ? frame_shape_t'(r - 9) : FR_GOOD;
        build_frame(shape, -1);
        send_frame();
      end
    end

    wait_idle();
    if (sb.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* frame_checker_crc32.f */
src/fcc_pkg.sv
src/fcc_in_stage.sv
src/fcc_parse.sv
src/fcc_out_stage.sv
src/frame_checker_crc32.sv
sim/testbench.sv
